>>> rtl/value_to_colormap_rgb_assert.svh
// Assertion macros for the colormap block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef VALUE_TO_COLORMAP_RGB_ASSERT_SVH
`define VALUE_TO_COLORMAP_RGB_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define V2CMAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define V2CMAP_NEVER(lbl, bad, msg) \
    `V2CMAP_ASSERT(lbl, !(bad), msg)

`endif

>>> rtl/v2cmap_pkg.sv
// Shared constants, register codes and colormap stop tables for the colormap block.
// No dependencies.
package v2cmap_pkg;

    localparam int T_FRACTION_BITS_DEF = 16;
    // Remainder and divisor width of the normalizing divider: twice a 33-bit span.
    localparam int DIV_W = 34;

    typedef enum logic [3:0] {
        KIND_VIRIDIS   = 4'd0,
        KIND_JET       = 4'd1,
        KIND_PARULA    = 4'd2,
        KIND_BWR       = 4'd3,
        KIND_TURBO     = 4'd4,
        KIND_COOLWARM  = 4'd5,
        KIND_MAGMA     = 4'd6,
        KIND_INFERNO   = 4'd7,
        KIND_PLASMA    = 4'd8,
        KIND_CIVIDIS   = 4'd9,
        KIND_ROCKET    = 4'd10,
        KIND_MAKO      = 4'd11,
        KIND_GRADIENT  = 4'd12,
        KIND_GRADIENT2 = 4'd13
    } map_kind_t;

    typedef enum logic [2:0] {
        REG_MAP_KIND   = 3'd0,
        REG_DATA_MIN   = 3'd1,
        REG_DATA_MAX   = 3'd2,
        REG_MID_VALUE  = 3'd3,
        REG_LOW_COLOR  = 3'd4,
        REG_MID_COLOR  = 3'd5,
        REG_HIGH_COLOR = 3'd6
    } reg_index_t;

    localparam int ROM_MAPS  = 12;
    localparam int ROM_STOPS = 11;

    localparam logic [23:0] STOP_ROM [0:ROM_MAPS-1][0:ROM_STOPS-1] = '{
        '{24'h440154, 24'h482878, 24'h3E4989, 24'h31688E, 24'h26828E, 24'h1F9E89,
          24'h35B779, 24'h6DCD59, 24'hB4DE2C, 24'hFDE725, 24'h000000},
        '{24'h00007F, 24'h0000FF, 24'h007FFF, 24'h00FFFF, 24'h7FFF7F, 24'hFFFF00,
          24'hFF7F00, 24'hFF0000, 24'h7F0000, 24'h000000, 24'h000000},
        '{24'h352A87, 24'h0F5CDD, 24'h127DD8, 24'h069CC5, 24'h21B49E, 24'h79BD69,
          24'hC2BD4A, 24'hFAC42C, 24'hF9FB0E, 24'h000000, 24'h000000},
        '{24'h0000FF, 24'hFFFFFF, 24'hFF0000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h30123B, 24'h414587, 24'h4677CC, 24'h2CA7E9, 24'h22CEC0, 24'h4BE586,
          24'h9AF33E, 24'hD1E521, 24'hF9B01F, 24'hEB620C, 24'hA00802},
        '{24'h3B4CC0, 24'h6883E1, 24'h9AB0F2, 24'hC6D4F0, 24'hDCDCDC, 24'hF2CBB7,
          24'hEE9174, 24'hD65B4A, 24'hB40426, 24'h000000, 24'h000000},
        '{24'h000004, 24'h1C1044, 24'h4F127B, 24'h812581, 24'hB63779, 24'hE1515B,
          24'hF8765C, 24'hFEB17B, 24'hFCFDBF, 24'h000000, 24'h000000},
        '{24'h000004, 24'h1F0C48, 24'h550F6D, 24'h88226A, 24'hB83B5B, 24'hE35B33,
          24'hF9890F, 24'hF9C032, 24'hFCFFA4, 24'h000000, 24'h000000},
        '{24'h0D0887, 24'h47029F, 24'h72029E, 24'h9C179E, 24'hBD3F86, 24'hD8576B,
          24'hED7953, 24'hFA9E3B, 24'hF0F921, 24'h000000, 24'h000000},
        '{24'h002051, 24'h0C386B, 24'h3B4D6E, 24'h57626D, 24'h70776E, 24'h8A8D6C,
          24'hA8A564, 24'hC8BE53, 24'hFDEA45, 24'h000000, 24'h000000},
        '{24'h03051A, 24'h35113A, 24'h69144B, 24'h9B1B4A, 24'hC6363B, 24'hE0603E,
          24'hEC8C64, 24'hF3B592, 24'hFAEBDD, 24'h000000, 24'h000000},
        '{24'h0B0405, 24'h2B1B3E, 24'h383A6E, 24'h355F8D, 24'h318293, 24'h36A593,
          24'h59C887, 24'hA5E28F, 24'hDEF5E5, 24'h000000, 24'h000000}
    };

    // Index of the last stop of each map.
    function automatic logic [3:0] stop_last(input logic [3:0] kind);
        logic [3:0] r;
        begin
            case (kind)
                KIND_BWR:       r = 4'd2;
                KIND_TURBO:     r = 4'd10;
                KIND_GRADIENT:  r = 4'd1;
                KIND_GRADIENT2: r = 4'd2;
                KIND_JET, KIND_PARULA, KIND_COOLWARM, KIND_MAGMA, KIND_INFERNO,
                KIND_PLASMA, KIND_CIVIDIS, KIND_ROCKET, KIND_MAKO: r = 4'd8;
                default:        r = 4'd9;
            endcase
            return r;
        end
    endfunction

    // Built-in stop lookup; unused map codes fall back to the first map.
    function automatic logic [23:0] rom_stop(input logic [3:0] kind, input logic [3:0] idx);
        logic [3:0] k;
        begin
            k = (kind < 4'(ROM_MAPS)) ? kind : KIND_VIRIDIS;
            if (idx < 4'(ROM_STOPS))
                return STOP_ROM[k][idx];
            return 24'h000000;
        end
    endfunction

endpackage

>>> rtl/v2cmap_sample_if.sv
// Input channel carrying one signed Q16.16 sample per word.
// No dependencies.
interface v2cmap_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

>>> rtl/v2cmap_rgb_if.sv
// Output channel carrying one 8.8 RGB triple per word.
// No dependencies.
interface v2cmap_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/v2cmap_norm.sv
// Front cell: picks the range case and sets up dividend, divisor and base of t.
// Depends on v2cmap_pkg.
module v2cmap_norm
    import v2cmap_pkg::*;
#(
    parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [31:0]         sample_value,
    input  logic [3:0]                 map_kind,
    input  logic signed [31:0]         data_min,
    input  logic signed [31:0]         data_max,
    input  logic signed [31:0]         mid_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DIV_W-1:0]           rem,
    output logic [DIV_W-1:0]           den,
    output logic [T_FRACTION_BITS:0]   base
);
    localparam int TW = T_FRACTION_BITS + 1;
    localparam logic [TW-1:0] T_ONE  = TW'(1) << T_FRACTION_BITS;
    localparam logic [TW-1:0] T_HALF = TW'(1) << (T_FRACTION_BITS - 1);

    logic signed [DIV_W-1:0] v, lo, hi, md;
    logic [DIV_W-1:0] num_next, den_next;
    logic [TW-1:0] base_next;
    logic valid_reg;
    logic [DIV_W-1:0] rem_reg, den_reg;
    logic [TW-1:0] base_reg;

    always_comb
    begin
        v  = DIV_W'(sample_value);
        lo = DIV_W'(data_min);
        hi = DIV_W'(data_max);
        md = DIV_W'(mid_value);
        // A zero dividend over a unit divisor leaves t at its base.
        num_next  = '0;
        den_next  = DIV_W'(1);
        base_next = '0;
        if (map_kind == KIND_GRADIENT2)
        begin
            if (v <= md)
            begin
                if (!(lo >= md || v <= lo))
                begin
                    num_next = DIV_W'(v - lo);
                    den_next = DIV_W'(md - lo) << 1;
                end
            end
            else if (hi <= md || v >= hi)
            begin
                base_next = T_ONE;
            end
            else
            begin
                base_next = T_HALF;
                num_next  = DIV_W'(v - md);
                den_next  = DIV_W'(hi - md) << 1;
            end
        end
        else if (hi <= lo)
        begin
            base_next = T_HALF;
        end
        else if (v >= hi)
        begin
            base_next = T_ONE;
        end
        else if (v > lo)
        begin
            num_next = DIV_W'(v - lo);
            den_next = DIV_W'(hi - lo);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg  <= num_next;
            den_reg  <= den_next;
            base_reg <= base_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem       = rem_reg;
    assign den       = den_reg;
    assign base      = base_reg;
endmodule

>>> rtl/v2cmap_div_cell.sv
// One restoring-division cell: yields one quotient bit of t per cycle unless its output stalls.
// Depends on v2cmap_pkg.
module v2cmap_div_cell
    import v2cmap_pkg::*;
#(
    parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [DIV_W-1:0]             rem_in,
    input  logic [DIV_W-1:0]             den_in,
    input  logic [T_FRACTION_BITS-1:0]   q_in,
    input  logic [T_FRACTION_BITS:0]     base_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DIV_W-1:0]             rem_out,
    output logic [DIV_W-1:0]             den_out,
    output logic [T_FRACTION_BITS-1:0]   q_out,
    output logic [T_FRACTION_BITS:0]     base_out
);
    logic [DIV_W:0] r2, diff;
    logic ge;
    logic valid_reg;
    logic [DIV_W-1:0] rem_reg, den_reg;
    logic [T_FRACTION_BITS-1:0] q_reg;
    logic [T_FRACTION_BITS:0] base_reg;

    always_comb
    begin
        r2   = {rem_in, 1'b0};
        diff = r2 - {1'b0, den_in};
        ge   = !diff[DIV_W];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg  <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
            den_reg  <= den_in;
            q_reg    <= {q_in[T_FRACTION_BITS-2:0], ge};
            base_reg <= base_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign q_out     = q_reg;
    assign base_out  = base_reg;
endmodule

>>> rtl/v2cmap_lerp.sv
// Stop selection and per-channel linear interpolation, two register stages.
// Depends on v2cmap_pkg.
module v2cmap_lerp
    import v2cmap_pkg::*;
#(
    parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [T_FRACTION_BITS-1:0]   q,
    input  logic [T_FRACTION_BITS:0]     base,
    input  logic [3:0]                   map_kind,
    input  logic [23:0]                  low_color,
    input  logic [23:0]                  mid_color,
    input  logic [23:0]                  high_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [15:0]                  red,
    output logic [15:0]                  green,
    output logic [15:0]                  blue
);
    localparam int F  = T_FRACTION_BITS;
    localparam int PW = F + 4;

    logic [F:0] t;
    logic [3:0] nm1;
    logic [PW-1:0] p;
    logic [3:0] idx_next;
    logic [F-1:0] f_next;

    logic s1_valid_reg, s2_valid_reg;
    logic s1_ready, s2_ready;
    logic [3:0] idx_reg;
    logic [F-1:0] f_reg;

    logic [23:0] s0, s1;
    logic [15:0] chan_next [0:2];
    logic [15:0] chan_reg [0:2];

    function automatic logic [23:0] pick(input logic [3:0] kind, input logic [3:0] i,
                                         input logic [23:0] lc, input logic [23:0] mc,
                                         input logic [23:0] hc);
        begin
            if (kind == KIND_GRADIENT)
                return (i == 4'd0) ? lc : hc;
            if (kind == KIND_GRADIENT2)
                return (i == 4'd0) ? lc : ((i == 4'd1) ? mc : hc);
            return rom_stop(kind, i);
        end
    endfunction

    // Stage one: position along the stops.
    always_comb
    begin
        t   = base + {1'b0, q};
        nm1 = stop_last(map_kind);
        p   = PW'(t[F-1:0]) * PW'(nm1);
        if (t[F])
        begin
            idx_next = nm1;
            f_next   = '0;
        end
        else
        begin
            idx_next = p[PW-1:F];
            f_next   = p[F-1:0];
        end
    end

    // Stage two: offset toward the next stop, truncated toward the lower one.
    always_comb
    begin
        logic [7:0] a, b, d;
        logic [F+7:0] prod;
        logic [F+15:0] sh;
        s0 = pick(map_kind, idx_reg, low_color, mid_color, high_color);
        s1 = pick(map_kind, idx_reg + 4'd1, low_color, mid_color, high_color);
        for (int ch = 0; ch < 3; ch++)
        begin
            a = s0[16 - 8 * ch +: 8];
            b = s1[16 - 8 * ch +: 8];
            d = (b >= a) ? b - a : a - b;
            prod = (F + 8)'(f_reg) * (F + 8)'(d);
            sh = {prod, 8'h00} >> F;
            if (b >= a)
                chan_next[ch] = {a, 8'h00} + sh[15:0];
            else
                chan_next[ch] = {a, 8'h00} - sh[15:0];
        end
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            idx_reg <= idx_next;
            f_reg   <= f_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            chan_reg[0] <= chan_next[0];
            chan_reg[1] <= chan_next[1];
            chan_reg[2] <= chan_next[2];
        end
    end

    assign out_valid = s2_valid_reg;
    assign red       = chan_reg[0];
    assign green     = chan_reg[1];
    assign blue      = chan_reg[2];
endmodule

>>> rtl/value_to_colormap_rgb.sv
// Colormap lookup: signed Q16.16 sample in, 8.8 RGB word out, one word per cycle unless out_s stalls.
// The pipeline holds one setup cell, one division cell per
// fraction bit of t, then the stop-select and interpolation stages.
// Throughput is one word per clock while the output accepts words.
// rst_n is asynchronous and clears all valid flags and loads register defaults.
// Depends on v2cmap_pkg, v2cmap_sample_if, v2cmap_rgb_if and the v2cmap cells.
`include "value_to_colormap_rgb_assert.svh"

module value_to_colormap_rgb
    import v2cmap_pkg::*;
#(
    parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    v2cmap_sample_if.sink       in_s,
    v2cmap_rgb_if.source        out_s,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int F = T_FRACTION_BITS;

    // Configuration registers. The user must change them only while the pipeline is empty;
    // the block does not enforce it. Every stage reads them directly instead of carrying a copy.
    logic [3:0]         map_kind_reg;
    logic signed [31:0] data_min_reg, data_max_reg, mid_value_reg;
    logic [23:0]        low_color_reg, mid_color_reg, high_color_reg;

    logic               wr_en;
    logic [2:0]         wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_kind_reg   <= KIND_VIRIDIS;
            data_min_reg   <= 32'sd0;
            data_max_reg   <= 32'sd65536;
            mid_value_reg  <= 32'sd32768;
            low_color_reg  <= 24'h000000;
            mid_color_reg  <= 24'hFFFFFF;
            high_color_reg <= 24'hFF0000;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_MAP_KIND:   map_kind_reg   <= pwdata[3:0];
                REG_DATA_MIN:   data_min_reg   <= pwdata;
                REG_DATA_MAX:   data_max_reg   <= pwdata;
                REG_MID_VALUE:  mid_value_reg  <= pwdata;
                REG_LOW_COLOR:  low_color_reg  <= pwdata[23:0];
                REG_MID_COLOR:  mid_color_reg  <= pwdata[23:0];
                REG_HIGH_COLOR: high_color_reg <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_MAP_KIND:   prdata = {28'h0, map_kind_reg};
            REG_DATA_MIN:   prdata = data_min_reg;
            REG_DATA_MAX:   prdata = data_max_reg;
            REG_MID_VALUE:  prdata = mid_value_reg;
            REG_LOW_COLOR:  prdata = {8'h00, low_color_reg};
            REG_MID_COLOR:  prdata = {8'h00, mid_color_reg};
            REG_HIGH_COLOR: prdata = {8'h00, high_color_reg};
            default:        prdata = 32'h0;
        endcase
    end

    // Link k feeds division cell k; link F carries the finished quotient.
    logic             lk_valid [0:F];
    logic             lk_ready [0:F];
    logic [DIV_W-1:0] lk_rem   [0:F];
    logic [DIV_W-1:0] lk_den   [0:F];
    logic [F-1:0]     lk_q     [0:F];
    logic [F:0]       lk_base  [0:F];

    v2cmap_norm #(
        .T_FRACTION_BITS(F)
    ) u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_s.valid),
        .in_ready     (in_s.ready),
        .sample_value (in_s.sample_value),
        .map_kind     (map_kind_reg),
        .data_min     (data_min_reg),
        .data_max     (data_max_reg),
        .mid_value    (mid_value_reg),
        .out_valid    (lk_valid[0]),
        .out_ready    (lk_ready[0]),
        .rem          (lk_rem[0]),
        .den          (lk_den[0]),
        .base         (lk_base[0])
    );

    assign lk_q[0] = '0;

    // The remainder starts below the divisor, so F cells give t's fraction bits.
    for (genvar k = 0; k < F; k++)
    begin : g_div
        v2cmap_div_cell #(
            .T_FRACTION_BITS(F)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .rem_in    (lk_rem[k]),
            .den_in    (lk_den[k]),
            .q_in      (lk_q[k]),
            .base_in   (lk_base[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .rem_out   (lk_rem[k+1]),
            .den_out   (lk_den[k+1]),
            .q_out     (lk_q[k+1]),
            .base_out  (lk_base[k+1])
        );
    end

    v2cmap_lerp #(
        .T_FRACTION_BITS(F)
    ) u_lerp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lk_valid[F]),
        .in_ready   (lk_ready[F]),
        .q          (lk_q[F]),
        .base       (lk_base[F]),
        .map_kind   (map_kind_reg),
        .low_color  (low_color_reg),
        .mid_color  (mid_color_reg),
        .high_color (high_color_reg),
        .out_valid  (out_s.valid),
        .out_ready  (out_s.ready),
        .red        (out_s.red),
        .green      (out_s.green),
        .blue       (out_s.blue)
    );

    // Interpolated channels never pass the top 8-bit level.
    `V2CMAP_NEVER(a_chan_range, out_s.valid && (out_s.red > 16'hFF00 || out_s.green > 16'hFF00 || out_s.blue > 16'hFF00), "channel above 8.8 full scale")
    // With the output drained every cell can move, so the input must be open.
    `V2CMAP_ASSERT(a_ready_chain, out_s.ready |-> in_s.ready, "input blocked with output ready")
    // A map selection write lands in the register on the next edge.
    `V2CMAP_ASSERT(a_kind_write, (wr_en && wr_idx == REG_MAP_KIND) |=> map_kind_reg == $past(pwdata[3:0]), "map selection write lost")
endmodule
